// File: rtl/core/grid_bilinear_interpolator_defines.svh
// ----------------------------------------------------------------------------
// Grid bilinear interpolator assertion macros
// Shared assertion forms for the checker of the interpolator.
// ----------------------------------------------------------------------------
`ifndef GRID_BILINEAR_INTERPOLATOR_DEFINES_SVH
`define GRID_BILINEAR_INTERPOLATOR_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define GBI_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GBI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/gbi_pkg.sv
// ----------------------------------------------------------------------------
// Grid bilinear interpolator package
// Sizes, codes and the controller/datapath link types.
// ----------------------------------------------------------------------------
package gbi_pkg;

    localparam int MAX_COLS    = 64;
    localparam int MAX_ROWS    = 64;
    localparam int FRAC_BITS   = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int GRID_DEPTH  = MAX_ROWS * MAX_COLS;

    localparam int IN_VALUE_W  = 32;
    localparam int OUT_VALUE_W = 32;
    localparam int LOAD_IDX_W  = 12;
    localparam int POS_W       = 22;
    localparam int INT_W       = POS_W - FRAC_BITS;
    localparam int DIM_W       = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int ADDR_W      = $clog2(GRID_DEPTH);
    localparam int WTERM_W     = FRAC_BITS + 1;
    localparam int WGT_W       = 2 * FRAC_BITS + 1;
    localparam int PROD_W      = VALUE_WIDTH + WGT_W + 1;
    localparam int ACC_W       = PROD_W;
    localparam int SUM_W       = 2 * DIM_W + 1;

    localparam logic [0:0] KIND_LOAD  = 1'b0;
    localparam logic [0:0] KIND_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'b1;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    typedef struct packed {
        logic       start;
        logic       write;
        logic       issue;
        logic [1:0] nbr;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        logic oor_in;
    } t_status;

endpackage

// File: rtl/core/gbi_in_if.sv
// ----------------------------------------------------------------------------
// Grid bilinear interpolator input channel
// Valid/ready channel carrying load and query words.
// ----------------------------------------------------------------------------
interface gbi_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   kind;
    logic [gbi_pkg::LOAD_IDX_W-1:0]         load_index;
    logic signed [gbi_pkg::IN_VALUE_W-1:0]  load_value;
    logic [gbi_pkg::POS_W-1:0]              pos_row;
    logic [gbi_pkg::POS_W-1:0]              pos_col;

    modport source (output valid, kind, load_index, load_value, pos_row, pos_col,
                    input ready);
    modport sink (input valid, kind, load_index, load_value, pos_row, pos_col,
                  output ready);
endinterface

// File: rtl/core/gbi_out_if.sv
// ----------------------------------------------------------------------------
// Grid bilinear interpolator result channel
// Valid/ready channel carrying interpolation results.
// ----------------------------------------------------------------------------
interface gbi_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [gbi_pkg::OUT_VALUE_W-1:0] interp_value;
    logic                                   out_of_range;

    modport source (output valid, interp_value, out_of_range, input ready);
    modport sink (input valid, interp_value, out_of_range, output ready);
endinterface

// File: rtl/core/gbi_cfg_if.sv
// ----------------------------------------------------------------------------
// Grid bilinear interpolator configuration channel
// Valid/ready write channel carrying a register index and data.
// ----------------------------------------------------------------------------
interface gbi_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [gbi_pkg::CFG_IDX_W-1:0]     index;
    logic [gbi_pkg::DIM_W-1:0]         data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/gbi_ctrl.sv
// ----------------------------------------------------------------------------
// Grid bilinear interpolator controller
// Sequences loads, the four neighbor reads of a query and the result word.
// ----------------------------------------------------------------------------
module gbi_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_kind,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    input  gbi_pkg::t_status i_status,
    output gbi_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;
    logic       in_acc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_acc      = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.nbr   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_kind == gbi_pkg::KIND_LOAD) begin
                        o_cmd.write = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_cnt       = 2'd0;
                        n_state     = i_status.oor_in ? S_FIN : S_READ;
                    end
                end
            end
            S_READ: begin
                o_cmd.issue = 1'b1;
                n_cnt       = r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd1) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: rtl/core/gbi_datapath.sv
// ----------------------------------------------------------------------------
// Grid bilinear interpolator datapath
// Grid memory, configuration registers, weight and address logic and MAC.
// ----------------------------------------------------------------------------
module gbi_datapath (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  gbi_pkg::t_cmd                           i_cmd,
    output gbi_pkg::t_status                        o_status,
    input  logic                                    i_cfg_we,
    input  logic [gbi_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [gbi_pkg::DIM_W-1:0]               i_cfg_data,
    input  logic [gbi_pkg::LOAD_IDX_W-1:0]          i_load_index,
    input  logic signed [gbi_pkg::IN_VALUE_W-1:0]   i_load_value,
    input  logic [gbi_pkg::POS_W-1:0]               i_pos_row,
    input  logic [gbi_pkg::POS_W-1:0]               i_pos_col,
    output logic signed [gbi_pkg::OUT_VALUE_W-1:0]  o_interp_value,
    output logic                                    o_out_of_range
);

    localparam logic [gbi_pkg::WTERM_W-1:0] ONE = gbi_pkg::WTERM_W'(1) << gbi_pkg::FRAC_BITS;

    logic [gbi_pkg::VALUE_WIDTH-1:0] mem [gbi_pkg::GRID_DEPTH];

    logic [gbi_pkg::DIM_W-1:0]           r_num_cols, r_num_rows;
    logic [gbi_pkg::DIM_W-1:0]           nc, nr;
    logic [gbi_pkg::INT_W-1:0]           r_ir, r_ic;
    logic [gbi_pkg::FRAC_BITS-1:0]       r_fr, r_fc;
    logic                                r_oor;
    logic signed [gbi_pkg::VALUE_WIDTH-1:0] r_rd;
    logic [gbi_pkg::WGT_W-1:0]           r_w_a;
    logic                                r_v_a, r_v_b;
    logic signed [gbi_pkg::PROD_W-1:0]   r_prod;
    logic signed [gbi_pkg::ACC_W-1:0]    r_acc;
    logic signed [gbi_pkg::OUT_VALUE_W-1:0] r_out_value;
    logic                                r_out_oor;

    logic [gbi_pkg::INT_W-1:0]           in_ir, in_ic;
    logic [gbi_pkg::FRAC_BITS-1:0]       in_fr, in_fc;
    logic                                row_bad, col_bad;
    logic                                dy, dx;
    logic [gbi_pkg::WTERM_W-1:0]         wy, wx;
    logic [2*gbi_pkg::WTERM_W-1:0]       wprod;
    logic [gbi_pkg::DIM_W-1:0]           row;
    logic [gbi_pkg::SUM_W-1:0]           sum_idx;
    logic                                rd_en;
    logic [gbi_pkg::ADDR_W-1:0]          addr;
    logic signed [gbi_pkg::PROD_W-1:0]   n_prod;

    function automatic logic [gbi_pkg::DIM_W-1:0] eff_dim(
        input logic [gbi_pkg::DIM_W-1:0] raw,
        input logic [gbi_pkg::DIM_W-1:0] maxv
    );
        logic [gbi_pkg::DIM_W-1:0] d;
        d = raw;
        if (raw == '0) begin
            d = gbi_pkg::DIM_W'(1);
        end else if (raw > maxv) begin
            d = maxv;
        end
        return d;
    endfunction

    always_comb begin
        nc = eff_dim(r_num_cols, gbi_pkg::DIM_W'(gbi_pkg::MAX_COLS));
        nr = eff_dim(r_num_rows, gbi_pkg::DIM_W'(gbi_pkg::MAX_ROWS));

        in_ir = i_pos_row[gbi_pkg::POS_W-1:gbi_pkg::FRAC_BITS];
        in_fr = i_pos_row[gbi_pkg::FRAC_BITS-1:0];
        in_ic = i_pos_col[gbi_pkg::POS_W-1:gbi_pkg::FRAC_BITS];
        in_fc = i_pos_col[gbi_pkg::FRAC_BITS-1:0];
        row_bad = (gbi_pkg::DIM_W'(in_ir) > nr - 1'b1) ||
                  ((gbi_pkg::DIM_W'(in_ir) == nr - 1'b1) && (in_fr != '0));
        col_bad = (gbi_pkg::DIM_W'(in_ic) > nc - 1'b1) ||
                  ((gbi_pkg::DIM_W'(in_ic) == nc - 1'b1) && (in_fc != '0));
        o_status.oor_in = row_bad || col_bad;

        dy    = i_cmd.nbr[1];
        dx    = i_cmd.nbr[0];
        wy    = dy ? gbi_pkg::WTERM_W'(r_fr) : ONE - gbi_pkg::WTERM_W'(r_fr);
        wx    = dx ? gbi_pkg::WTERM_W'(r_fc) : ONE - gbi_pkg::WTERM_W'(r_fc);
        wprod = wy * wx;

        row     = gbi_pkg::DIM_W'(r_ir) + gbi_pkg::DIM_W'(dy);
        sum_idx = gbi_pkg::SUM_W'(row) * gbi_pkg::SUM_W'(nc) + gbi_pkg::SUM_W'(r_ic) +
                  gbi_pkg::SUM_W'(dx);
        rd_en   = i_cmd.issue && !r_oor && (wy != '0) && (wx != '0) &&
                  (sum_idx < gbi_pkg::SUM_W'(gbi_pkg::GRID_DEPTH));
        addr    = i_cmd.write ? i_load_index[gbi_pkg::ADDR_W-1:0]
                              : sum_idx[gbi_pkg::ADDR_W-1:0];

        n_prod = r_rd * $signed({1'b0, r_w_a});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            mem[addr] <= i_load_value[gbi_pkg::VALUE_WIDTH-1:0];
        end else if (rd_en) begin
            r_rd <= mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cols <= gbi_pkg::DIM_RESET;
            r_num_rows <= gbi_pkg::DIM_RESET;
            r_v_a      <= 1'b0;
            r_v_b      <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == gbi_pkg::REG_NUM_COLS) begin
                r_num_cols <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == gbi_pkg::REG_NUM_ROWS) begin
                r_num_rows <= i_cfg_data;
            end
            r_v_a <= rd_en;
            r_v_b <= r_v_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_ir  <= in_ir;
            r_ic  <= in_ic;
            r_fr  <= in_fr;
            r_fc  <= in_fc;
            r_oor <= o_status.oor_in;
        end
        r_w_a  <= wprod[gbi_pkg::WGT_W-1:0];
        r_prod <= n_prod;
        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (r_v_b) begin
            r_acc <= r_acc + r_prod;
        end
        if (i_cmd.load_out) begin
            r_out_oor   <= r_oor;
            r_out_value <= r_oor ? '0
                                 : r_acc[2*gbi_pkg::FRAC_BITS +: gbi_pkg::OUT_VALUE_W];
        end
    end

    assign o_interp_value = r_out_value;
    assign o_out_of_range = r_out_oor;

endmodule

// File: rtl/core/grid_bilinear_interpolator.sv
// ----------------------------------------------------------------------------
// Grid bilinear interpolator
// Row-major Q16.16 grid with load words and bilinear query words.
//
// Channel   Direction  Word
// i_in      in         kind, load_index, load_value, pos_row, pos_col
// o_out     out        interp_value, out_of_range
// i_cfg     in         index, data (num_cols, num_rows)
//
// A load word is written to the single-port grid memory at its acceptance edge.
// An in-range query's result word passes through four neighbor reads on the memory
// port, the multiplier and adder registers, and then the result register. An
// out-of-range query skips the reads and goes straight to the result register.
// The input is ready again when the result word becomes valid, so a query blocks
// the input until then. One query is in flight at a time.
// The result register holds its word under stall; loads are still taken then.
// Reset clears control and configuration only; the grid is not cleared.
// ----------------------------------------------------------------------------
module grid_bilinear_interpolator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gbi_in_if.sink    i_in,
    gbi_out_if.source o_out,
    gbi_cfg_if.sink   i_cfg
);

    gbi_pkg::t_cmd    cmd;
    gbi_pkg::t_status status;

    assign i_cfg.ready = 1'b1;

    gbi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_kind   (i_in.kind),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    gbi_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_load_index   (i_in.load_index),
        .i_load_value   (i_in.load_value),
        .i_pos_row      (i_in.pos_row),
        .i_pos_col      (i_in.pos_col),
        .o_interp_value (o_out.interp_value),
        .o_out_of_range (o_out.out_of_range)
    );

endmodule

// File: rtl/core/gbi_checker.sv
// ----------------------------------------------------------------------------
// Grid bilinear interpolator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "grid_bilinear_interpolator_defines.svh"

module gbi_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_in_valid,
    input logic                                   i_in_ready,
    input logic                                   i_in_kind,
    input logic                                   i_out_valid,
    input logic                                   i_out_ready,
    input logic signed [gbi_pkg::OUT_VALUE_W-1:0] i_interp_value,
    input logic                                   i_out_of_range
);

    `GBI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result word dropped under stall")
    `GBI_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_interp_value) && $stable(i_out_of_range), "result word changed under stall")
    `GBI_ASSERT_SAME(a_oor_zero, i_clk, i_rst_n, i_out_valid && i_out_of_range, i_interp_value == '0, "out-of-range word carries a nonzero value")
    `GBI_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_kind == gbi_pkg::KIND_QUERY), !i_in_ready, "word accepted while a query is in flight")

endmodule

bind grid_bilinear_interpolator gbi_checker u_gbi_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_kind      (i_in.kind),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_interp_value (o_out.interp_value),
    .i_out_of_range (o_out.out_of_range)
);

// File: dv/gbi_interp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid bilinear interpolator checker
// Watches the load/query, result and register channels. It keeps its own
// copy of the grid and of the dimension registers. It works out the
// interpolated value of each accepted query word and compares every
// accepted result word with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module gbi_interp_checker
    import gbi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    gbi_in_if    i_in,
    gbi_out_if   i_res,
    gbi_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_result_count,
    output int   o_oor_count
);

    localparam int WIDE = 2 * VALUE_WIDTH + 16;

    typedef struct packed {
        logic signed [OUT_VALUE_W-1:0] value;
        logic                          oor;
    } t_result;

    logic signed [VALUE_WIDTH-1:0] grid_mem [GRID_DEPTH];
    logic [DIM_W-1:0]              cols_reg;
    logic [DIM_W-1:0]              rows_reg;
    t_result                       due_results [$];
    int                            fails;
    int                            results;
    int                            oor_results;

    function automatic int dim_in_use(logic [DIM_W-1:0] raw, int limit);
        if (raw == '0) return 1;
        if (int'(raw) > limit) return limit;
        return int'(raw);
    endfunction

    function automatic t_result interpolate(logic [POS_W-1:0] prow, logic [POS_W-1:0] pcol);
        int                   nr;
        int                   nc;
        int                   ir;
        int                   ic;
        int                   idx;
        logic [FRAC_BITS-1:0] fr;
        logic [FRAC_BITS-1:0] fc;
        logic [WTERM_W-1:0]   wy [2];
        logic [WTERM_W-1:0]   wx [2];
        logic [WGT_W-1:0]     wgt;
        logic signed [WIDE-1:0] term;
        logic signed [WIDE-1:0] acc;
        t_result              r;
        nr = dim_in_use(rows_reg, MAX_ROWS);
        nc = dim_in_use(cols_reg, MAX_COLS);
        ir = int'(prow[POS_W-1:FRAC_BITS]);
        ic = int'(pcol[POS_W-1:FRAC_BITS]);
        fr = prow[FRAC_BITS-1:0];
        fc = pcol[FRAC_BITS-1:0];
        r.value = '0;
        r.oor   = 1'b1;
        if (ir > nr - 1 || (ir == nr - 1 && fr != '0) ||
            ic > nc - 1 || (ic == nc - 1 && fc != '0)) begin
            return r;
        end
        wy[0] = {1'b1, {FRAC_BITS{1'b0}}} - fr;
        wy[1] = fr;
        wx[0] = {1'b1, {FRAC_BITS{1'b0}}} - fc;
        wx[1] = fc;
        acc = '0;
        for (int dy = 0; dy < 2; dy++) begin
            for (int dx = 0; dx < 2; dx++) begin
                if (wy[dy] != '0 && wx[dx] != '0) begin
                    idx = (ir + dy) * nc + ic + dx;
                    if (idx < GRID_DEPTH) begin
                        wgt  = wy[dy] * wx[dx];
                        term = WIDE'(grid_mem[idx]);
                        acc  = acc + term * $signed({{(WIDE - WGT_W){1'b0}}, wgt});
                    end
                end
            end
        end
        // An arithmetic shift of the exact sum rounds toward minus infinity.
        r.value = acc[2*FRAC_BITS +: OUT_VALUE_W];
        r.oor   = 1'b0;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            cols_reg = DIM_RESET;
            rows_reg = DIM_RESET;
            due_results.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got.value = i_res.interp_value;
                got.oor   = i_res.out_of_range;
                results++;
                if (due_results.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("[%0t] unexpected result word: value %h oor %b",
                                 $realtime, got.value, got.oor);
                    end
                end else begin
                    want = due_results.pop_front();
                    if (want.oor) oor_results++;
                    if (got.value !== want.value || got.oor !== want.oor) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("[%0t] result %0d: expected value %h oor %b, got value %h oor %b",
                                     $realtime, results, want.value, want.oor,
                                     got.value, got.oor);
                        end
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_NUM_COLS: cols_reg = i_cfg.data;
                    REG_NUM_ROWS: rows_reg = i_cfg.data;
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                if (i_in.kind == KIND_LOAD) begin
                    if (int'(i_in.load_index) < GRID_DEPTH) begin
                        grid_mem[i_in.load_index] = i_in.load_value;
                    end
                end else begin
                    due_results.push_back(interpolate(i_in.pos_row, i_in.pos_col));
                end
            end
        end
        o_pending      <= due_results.size();
        o_fail_count   <= fails;
        o_result_count <= results;
        o_oor_count    <= oor_results;
    end

endmodule

// File: dv/tb_grid_bilinear_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid bilinear interpolator testbench
// Drives load and query words with random gaps and random result stalls,
// steps the dimension registers through a range of settings, and leaves
// prediction and comparison to the checker. Queries only touch grid entries
// that were loaded before.
// ----------------------------------------------------------------------------
module tb_grid_bilinear_interpolator;
    import gbi_pkg::*;

    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_WORDS   = 112;
    localparam int N_SETTINGS    = 10;

    logic i_clk;
    logic i_rst_n;

    gbi_in_if  in_ch ();
    gbi_out_if res_ch ();
    gbi_cfg_if cfg_ch ();

    int fail_count;
    int pending;
    int result_count;
    int oor_count;
    int words_sent;
    int loads_sent;
    int queries_sent;
    int settings_run;
    int idle_cycles;
    int cols_eff;
    int rows_eff;
    bit steady_input;
    bit written [GRID_DEPTH];

    int col_plan [N_SETTINGS] = '{1, 0, 127, 2, 65, 1, 64, 5, -1, -1};
    int row_plan [N_SETTINGS] = '{1, 0, 127, 2, 1, 100, 64, 3, -1, -1};

    grid_bilinear_interpolator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (res_ch),
        .i_cfg   (cfg_ch)
    );

    gbi_interp_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (in_ch),
        .i_res          (res_ch),
        .i_cfg          (cfg_ch),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_oor_count    (oor_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [IN_VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return '1;
            4: return $urandom_range(0, 32'h0003_FFFF);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [FRAC_BITS-1:0] pick_frac();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 16'h8000;
            3: return 16'h0001;
            default: return FRAC_BITS'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    task automatic push_word(logic kind, logic [LOAD_IDX_W-1:0] idx,
                             logic [IN_VALUE_W-1:0] value,
                             logic [POS_W-1:0] prow, logic [POS_W-1:0] pcol);
        int gap;
        gap = steady_input ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= kind;
        in_ch.load_index <= idx;
        in_ch.load_value <= value;
        in_ch.pos_row    <= prow;
        in_ch.pos_col    <= pcol;
        do @(posedge i_clk); while (!in_ch.ready);
        words_sent++;
    endtask

    task automatic push_load(int idx, logic [IN_VALUE_W-1:0] value);
        written[idx] = 1'b1;
        push_word(KIND_LOAD, LOAD_IDX_W'(idx), value,
                  POS_W'($urandom_range(0, 22'h3F_FFFF)),
                  POS_W'($urandom_range(0, 22'h3F_FFFF)));
        loads_sent++;
    endtask

    // Neighbors with a nonzero weight are loaded first if they were never written.
    task automatic query_at(logic [POS_W-1:0] prow, logic [POS_W-1:0] pcol);
        int                   ir;
        int                   ic;
        int                   idx;
        logic [FRAC_BITS-1:0] fr;
        logic [FRAC_BITS-1:0] fc;
        bit                   in_range;
        ir = int'(prow[POS_W-1:FRAC_BITS]);
        ic = int'(pcol[POS_W-1:FRAC_BITS]);
        fr = prow[FRAC_BITS-1:0];
        fc = pcol[FRAC_BITS-1:0];
        in_range = !(ir > rows_eff - 1 || (ir == rows_eff - 1 && fr != '0) ||
                     ic > cols_eff - 1 || (ic == cols_eff - 1 && fc != '0));
        if (in_range) begin
            for (int dy = 0; dy < 2; dy++) begin
                for (int dx = 0; dx < 2; dx++) begin
                    if ((dy == 0 || fr != '0) && (dx == 0 || fc != '0)) begin
                        idx = (ir + dy) * cols_eff + ic + dx;
                        if (!written[idx]) push_load(idx, pick_value());
                    end
                end
            end
        end
        push_word(KIND_QUERY, LOAD_IDX_W'($urandom_range(0, GRID_DEPTH - 1)), $urandom(),
                  prow, pcol);
        queries_sent++;
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_dims(int cols, int rows);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= REG_NUM_COLS;
        cfg_ch.data  <= DIM_W'(cols);
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.index <= REG_NUM_ROWS;
        cfg_ch.data  <= DIM_W'(rows);
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        cols_eff = (cols == 0) ? 1 : ((cols > MAX_COLS) ? MAX_COLS : cols);
        rows_eff = (rows == 0) ? 1 : ((rows > MAX_ROWS) ? MAX_ROWS : rows);
        settings_run++;
    endtask

    task automatic random_phase(int count);
        int                   stop;
        int                   r;
        int                   ir;
        int                   ic;
        logic [FRAC_BITS-1:0] fr;
        logic [FRAC_BITS-1:0] fc;
        stop = words_sent + count;
        steady_input = ($urandom_range(0, 3) == 0);
        while (words_sent < stop) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                push_load($urandom_range(0, GRID_DEPTH - 1), pick_value());
            end else if (r < 80) begin
                ir = $urandom_range(0, rows_eff - 1);
                ic = $urandom_range(0, cols_eff - 1);
                fr = (ir == rows_eff - 1) ? '0 : pick_frac();
                fc = (ic == cols_eff - 1) ? '0 : pick_frac();
                query_at({ir[INT_W-1:0], fr}, {ic[INT_W-1:0], fc});
            end else if (r < 90) begin
                if ($urandom_range(0, 1) == 1) begin
                    query_at(POS_W'(((rows_eff - 1) << FRAC_BITS) + $urandom_range(1, 16'hFFFF)),
                             POS_W'($urandom_range(0, 22'h3F_FFFF)));
                end else begin
                    query_at(POS_W'($urandom_range(0, 22'h3F_FFFF)),
                             POS_W'(((cols_eff - 1) << FRAC_BITS) + $urandom_range(1, 16'hFFFF)));
                end
            end else begin
                query_at(POS_W'($urandom_range(0, 22'h3F_FFFF)),
                         POS_W'($urandom_range(0, 22'h3F_FFFF)));
            end
            if ($urandom_range(0, 63) == 0) steady_input = !steady_input;
        end
        steady_input = 1'b0;
    endtask

    initial begin : result_stall
        int run;
        int gap;
        forever begin
            res_ch.ready <= 1'b1;
            run = $urandom_range(1, 40);
            repeat (run) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Stalled after %0d words and %0d checked result words.",
                     words_sent, result_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.kind       <= KIND_LOAD;
        in_ch.load_index <= '0;
        in_ch.load_value <= '0;
        in_ch.pos_row    <= '0;
        in_ch.pos_col    <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= REG_NUM_COLS;
        cfg_ch.data      <= '0;
        cols_eff     = MAX_COLS;
        rows_eff     = MAX_ROWS;
        steady_input = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_load(0, 32'h7FFF_FFFF);
        push_load(1, 32'h8000_0000);
        push_load(64, 32'hFFFF_FFFF);
        push_load(65, 32'h0001_0000);
        push_load(GRID_DEPTH - 1, 32'h5A5A_A5A5);
        query_at(22'h00_0000, 22'h00_0000);
        query_at(22'h00_8000, 22'h00_8000);
        query_at(22'h00_FFFF, 22'h00_FFFF);
        query_at({6'd63, 16'h0000}, {6'd63, 16'h0000});
        query_at({6'd63, 16'h0000}, {6'd62, 16'h4000});
        query_at({6'd62, 16'hC000}, {6'd63, 16'h0000});
        query_at({6'd63, 16'h0001}, 22'h00_0000);
        query_at(22'h00_0000, {6'd63, 16'h0001});
        query_at(22'h3F_FFFF, 22'h3F_FFFF);
        push_load(0, 32'h8000_0000);
        push_load(64, 32'h8000_0000);
        push_load(65, 32'h8000_0000);
        query_at(22'h00_8000, 22'h00_8000);
        query_at(22'h00_FFFF, 22'h00_0001);
        random_phase(PHASE_WORDS);

        for (int i = 0; i < N_SETTINGS; i++) begin
            settle();
            set_dims((col_plan[i] < 0) ? $urandom_range(0, 127) : col_plan[i],
                     (row_plan[i] < 0) ? $urandom_range(0, 127) : row_plan[i]);
            random_phase(PHASE_WORDS);
        end
        settle();

        $display("Drove %0d words (%0d loads, %0d queries) over %0d register settings.",
                 words_sent, loads_sent, queries_sent, settings_run + 1);
        $display("Checked %0d result words, %0d out of range, %0d failures.",
                 result_count, oor_count, fail_count);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
